// ===== hdl/arac_pkg.sv =====
// ============================================================================
// arac_pkg
// Shared constants, codes and types of the address range allocator.
// ============================================================================
`default_nettype none

package arac_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int ADDR_BITS_DEF = 48;
    localparam int FIELD_BITS    = 48;
    localparam int CALC_BITS     = 64;
    localparam int MERGE_STEPS   = 3;
    localparam int STEP_BITS     = 2;

    localparam int S_TDATA_W = 152;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK,
        S_SCAN,
        S_PICK,
        S_RM,
        S_FIND,
        S_SHIFT,
        S_PUT,
        S_MCHK,
        S_MRD0,
        S_MRD1,
        S_MUPD,
        S_RESP
    } t_state;

    typedef struct packed {
        logic valid;
        logic fits;
        logic aligned;
    } t_fit_flags;

endpackage

`default_nettype wire

// ===== hdl/address_range_allocator_top.sv =====
// ============================================================================
// address_range_allocator_top
// Free range table with first fit and best fit allocation and merging free.
// ============================================================================
// The block keeps up to ENTRIES free ranges [start, end) sorted by end, with
// the used entries always forming a prefix of the table. It takes one item
// at a time: s_axis_tready is high only while the block is idle, and each
// item returns exactly one result item on the master side. Every pass over
// the table goes through the single read port of the range memory, one
// entry per cycle. An allocate scans the table through the three stage fit
// unit (stopping early when the search ends), then writes back or, when an
// entry must be removed or a range cut, shifts entries. A free scans for
// its insert position, shifts the entries above it up, and then runs up
// to three merge checks, each merge that removes an entry adding a shift
// of the entries above it. The table starts empty after reset, so no
// clearing pass is run. Input addresses are masked to ADDR_BITS, but the
// table and the fit unit work on 64 bit values, so a start aligned up past
// the address space keeps its full value when a zero size request cuts a
// range there.
`default_nettype none

module address_range_allocator_top #(
    parameter int ENTRIES   = arac_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = arac_pkg::ADDR_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // range_start[47:0], range_end[95:48], alloc_size[143:96],
    // align_log2[149:144], best_fit[150], zero[151]
    input  wire logic [arac_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op[0]: 0 allocate, 1 free
    input  wire logic [arac_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // status[1:0], block_base[49:2], zero[55:50]
    output logic      [arac_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int AB = arac_pkg::CALC_BITS;
    localparam int FB = arac_pkg::FIELD_BITS;
    localparam int SB = arac_pkg::STEP_BITS;
    localparam logic [AB-1:0] ADDR_MASK = {AB{1'b1}} >> (AB - ADDR_BITS);

    arac_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_n, n_n, r_j, n_j;
    logic          r_rv, n_rv, r_wv, n_wv;
    logic [IW-1:0] r_rk, n_rk, r_wa, n_wa, r_p, n_p, r_cur, n_cur, r_bidx, n_bidx;
    logic [SB-1:0] r_steps, n_steps;
    logic [AB-1:0] r_s, n_s, r_e, n_e, r_size, n_size, r_amask, n_amask;
    logic [AB-1:0] r_score, n_score, r_bal, n_bal, r_bstart, n_bstart;
    logic [AB-1:0] r_bend, n_bend, r_pe, n_pe;
    logic          r_bf, n_bf, r_have, n_have, r_baligned, n_baligned;
    logic          r_merge_en, n_merge_en, r_tail_pend, n_tail_pend;
    logic          r_ins_pend, n_ins_pend, r_in_merge, n_in_merge;
    logic [1:0]    r_status, n_status;
    logic [FB-1:0] r_base, n_base;

    // Memory and fit unit connections.
    logic [IW-1:0] w_raddr, w_waddr;
    logic          w_we_start, w_we_end;
    logic [AB-1:0] w_wstart, w_wend, w_rd_start, w_rd_end;
    arac_pkg::t_fit_flags w_fit;
    logic          w_fit_busy, w_flush;
    logic [IW-1:0] w_fit_idx;
    logic [AB-1:0] w_fit_al, w_fit_start, w_fit_end, w_fit_slack;

    // Conditions shared by the next state and register logic.
    logic          s_fire, m_fire, w_full, w_issue, w_take, w_stop, w_scan_done;
    logic          w_found, w_find_end, w_rm_rd, w_sh_rd, w_join, w_remove, w_tail;
    logic [AB-1:0] w_sum, w_new_pe, w_in_s, w_in_e;

    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign m_fire  = m_axis_tvalid && m_axis_tready;
    assign w_full  = (r_n == CW'(ENTRIES));
    assign w_issue = (r_j < r_n);
    assign w_in_s  = AB'(s_axis_tdata[FB-1:0]) & ADDR_MASK;
    assign w_in_e  = AB'(s_axis_tdata[2*FB-1:FB]) & ADDR_MASK;

    // Allocation search: a fitting range is taken when nothing is held yet
    // or its slack is no worse; an exact fit or first fit ends the search.
    assign w_take      = w_fit.valid && w_fit.fits && (!r_have || w_fit_slack <= r_score);
    assign w_stop      = w_take && (w_fit_slack == '0 || !r_bf);
    assign w_scan_done = !w_issue && !r_rv && !w_fit_busy;
    assign w_flush     = (r_state == arac_pkg::S_SCAN) && (n_state != arac_pkg::S_SCAN);

    assign w_sum  = r_bal + r_size;
    assign w_tail = (w_sum != r_bend);

    assign w_found    = r_rv && (w_rd_end > r_e);
    assign w_find_end = !w_issue && !r_rv;
    assign w_rm_rd    = w_issue;
    assign w_sh_rd    = (r_j > CW'(r_p));

    // Merge: the previous entry takes over the current end when they touch,
    // and the current entry goes when both now end at the same address.
    assign w_join   = (r_pe == w_rd_start);
    assign w_new_pe = w_join ? w_rd_end : r_pe;
    assign w_remove = (w_new_pe == w_rd_end);

    arac_mem #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (AB)
    ) u_mem (
        .i_clk      (i_clk),
        .i_raddr    (w_raddr),
        .o_rd_start (w_rd_start),
        .o_rd_end   (w_rd_end),
        .i_we_start (w_we_start),
        .i_we_end   (w_we_end),
        .i_waddr    (w_waddr),
        .i_wstart   (w_wstart),
        .i_wend     (w_wend)
    );

    arac_fit #(
        .ENTRIES   (ENTRIES),
        .ADDR_BITS (AB)
    ) u_fit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_flush),
        .i_valid (r_rv && (r_state == arac_pkg::S_SCAN)),
        .i_idx   (r_rk),
        .i_start (w_rd_start),
        .i_end   (w_rd_end),
        .i_amask (r_amask),
        .i_size  (r_size),
        .o_flags (w_fit),
        .o_busy  (w_fit_busy),
        .o_idx   (w_fit_idx),
        .o_al    (w_fit_al),
        .o_start (w_fit_start),
        .o_end   (w_fit_end),
        .o_slack (w_fit_slack)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arac_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_state = (s_axis_tuser[0] == arac_pkg::OP_FREE) ? arac_pkg::S_CHK
                                                                     : arac_pkg::S_SCAN;
                end
            end
            arac_pkg::S_CHK: begin
                n_state = (r_s >= r_e || w_full) ? arac_pkg::S_RESP : arac_pkg::S_FIND;
            end
            arac_pkg::S_SCAN: begin
                if (w_stop || w_scan_done) begin
                    n_state = arac_pkg::S_PICK;
                end
            end
            arac_pkg::S_PICK: begin
                if (!r_have) begin
                    n_state = arac_pkg::S_RESP;
                end else if (r_baligned) begin
                    n_state = (w_sum == r_bend) ? arac_pkg::S_RM : arac_pkg::S_RESP;
                end else begin
                    n_state = (w_tail && w_full) ? arac_pkg::S_RESP : arac_pkg::S_RM;
                end
            end
            arac_pkg::S_RM: begin
                if (!w_rm_rd && !r_wv) begin
                    if (r_in_merge) begin
                        n_state = arac_pkg::S_MCHK;
                    end else if (r_ins_pend) begin
                        n_state = arac_pkg::S_FIND;
                    end else begin
                        n_state = arac_pkg::S_RESP;
                    end
                end
            end
            arac_pkg::S_FIND: begin
                if (w_found || w_find_end) begin
                    n_state = arac_pkg::S_SHIFT;
                end
            end
            arac_pkg::S_SHIFT: begin
                if (!w_sh_rd && !r_wv) begin
                    n_state = arac_pkg::S_PUT;
                end
            end
            arac_pkg::S_PUT: begin
                if (r_merge_en) begin
                    n_state = arac_pkg::S_MCHK;
                end else if (r_tail_pend) begin
                    n_state = arac_pkg::S_FIND;
                end else begin
                    n_state = arac_pkg::S_RESP;
                end
            end
            arac_pkg::S_MCHK: begin
                n_state = (r_steps == SB'(arac_pkg::MERGE_STEPS) || r_cur == '0)
                          ? arac_pkg::S_RESP : arac_pkg::S_MRD0;
            end
            arac_pkg::S_MRD0: n_state = arac_pkg::S_MRD1;
            arac_pkg::S_MRD1: n_state = arac_pkg::S_MUPD;
            arac_pkg::S_MUPD: begin
                n_state = w_remove ? arac_pkg::S_RM : arac_pkg::S_MCHK;
            end
            arac_pkg::S_RESP: begin
                if (m_fire) begin
                    n_state = arac_pkg::S_IDLE;
                end
            end
            default: n_state = arac_pkg::S_IDLE;
        endcase
    end

    // Outputs: handshake, memory read address and writes.
    always_comb begin
        s_axis_tready = (r_state == arac_pkg::S_IDLE);
        m_axis_tvalid = (r_state == arac_pkg::S_RESP);
        m_axis_tdata  = {(arac_pkg::M_TDATA_W - FB - 2)'(0), r_base, r_status};

        w_raddr    = r_j[IW-1:0];
        w_we_start = 1'b0;
        w_we_end   = 1'b0;
        w_waddr    = r_wa;
        w_wstart   = w_rd_start;
        w_wend     = w_rd_end;

        unique case (r_state)
            arac_pkg::S_RM: begin
                w_we_start = r_wv;
                w_we_end   = r_wv;
            end
            arac_pkg::S_SHIFT: begin
                w_raddr    = IW'(r_j - CW'(1));
                w_we_start = r_wv;
                w_we_end   = r_wv;
            end
            arac_pkg::S_PUT: begin
                w_we_start = 1'b1;
                w_we_end   = 1'b1;
                w_waddr    = r_p;
                w_wstart   = r_s;
                w_wend     = r_e;
            end
            arac_pkg::S_PICK: begin
                w_waddr    = r_bidx;
                w_wstart   = w_sum;
                w_we_start = r_have && r_baligned && (w_sum != r_bend);
            end
            arac_pkg::S_MRD0: w_raddr = r_cur - IW'(1);
            arac_pkg::S_MRD1: w_raddr = r_cur;
            arac_pkg::S_MUPD: begin
                w_we_end = w_join;
                w_waddr  = r_cur - IW'(1);
                w_wend   = w_rd_end;
            end
            default: begin
            end
        endcase
    end

    // Next values of the working registers.
    always_comb begin
        n_n = r_n;  n_j = r_j;  n_rv = 1'b0;  n_wv = 1'b0;
        n_rk = r_j[IW-1:0];  n_wa = r_wa;  n_p = r_p;  n_cur = r_cur;
        n_steps = r_steps;  n_s = r_s;  n_e = r_e;  n_size = r_size;
        n_amask = r_amask;  n_bf = r_bf;  n_have = r_have;
        n_score = r_score;  n_bidx = r_bidx;  n_bal = r_bal;
        n_bstart = r_bstart;  n_bend = r_bend;  n_baligned = r_baligned;
        n_pe = r_pe;  n_merge_en = r_merge_en;  n_tail_pend = r_tail_pend;
        n_ins_pend = r_ins_pend;  n_in_merge = r_in_merge;
        n_status = r_status;  n_base = r_base;

        unique case (r_state)
            arac_pkg::S_IDLE: begin
                if (s_fire) begin
                    n_s     = w_in_s;
                    n_e     = w_in_e;
                    n_size  = AB'(s_axis_tdata[3*FB-1:2*FB]) & ADDR_MASK;
                    n_amask = ~({AB{1'b1}} << s_axis_tdata[3*FB+5:3*FB]);
                    n_bf    = s_axis_tdata[3*FB+6];
                    n_j     = '0;
                    n_have  = 1'b0;
                    n_status    = arac_pkg::ST_OK;
                    n_base      = '0;
                    n_merge_en  = 1'b0;
                    n_tail_pend = 1'b0;
                    n_ins_pend  = 1'b0;
                    n_in_merge  = 1'b0;
                end
            end
            arac_pkg::S_CHK: begin
                if (r_s < r_e) begin
                    if (w_full) begin
                        n_status = arac_pkg::ST_FULL;
                    end else begin
                        n_merge_en = 1'b1;
                        n_j        = '0;
                    end
                end
            end
            arac_pkg::S_SCAN: begin
                if (w_issue) begin
                    n_j = r_j + CW'(1);
                end
                n_rv = w_issue && (n_state == arac_pkg::S_SCAN);
                if (w_take) begin
                    n_have     = 1'b1;
                    n_score    = w_fit_slack;
                    n_bidx     = w_fit_idx;
                    n_bal      = w_fit_al;
                    n_bstart   = w_fit_start;
                    n_bend     = w_fit_end;
                    n_baligned = w_fit.aligned;
                end
            end
            arac_pkg::S_PICK: begin
                if (!r_have) begin
                    n_status = arac_pkg::ST_NOFIT;
                end else if (r_baligned) begin
                    n_base = FB'(r_bal);
                    n_p    = r_bidx;
                    n_j    = CW'(r_bidx) + CW'(1);
                end else if (w_tail && w_full) begin
                    n_status = arac_pkg::ST_FULL;
                end else begin
                    n_base      = FB'(r_bal);
                    n_p         = r_bidx;
                    n_j         = CW'(r_bidx) + CW'(1);
                    n_ins_pend  = 1'b1;
                    n_s         = r_bstart;
                    n_e         = r_bal;
                    n_tail_pend = w_tail;
                    n_merge_en  = 1'b0;
                end
            end
            arac_pkg::S_RM: begin
                if (w_rm_rd) begin
                    n_j = r_j + CW'(1);
                end
                n_wv = w_rm_rd;
                n_wa = IW'(r_j - CW'(1));
                if (!w_rm_rd && !r_wv) begin
                    n_n = r_n - CW'(1);
                    if (r_in_merge) begin
                        n_in_merge = 1'b0;
                    end else if (r_ins_pend) begin
                        n_ins_pend = 1'b0;
                        n_j        = '0;
                    end
                end
            end
            arac_pkg::S_FIND: begin
                if (w_issue) begin
                    n_j = r_j + CW'(1);
                end
                n_rv = w_issue && (n_state == arac_pkg::S_FIND);
                if (w_found) begin
                    n_p = r_rk;
                    n_j = r_n;
                end else if (w_find_end) begin
                    n_p = IW'(r_n);
                    n_j = r_n;
                end
            end
            arac_pkg::S_SHIFT: begin
                if (w_sh_rd) begin
                    n_j = r_j - CW'(1);
                end
                n_wv = w_sh_rd;
                n_wa = r_j[IW-1:0];
            end
            arac_pkg::S_PUT: begin
                n_n = r_n + CW'(1);
                if (r_merge_en) begin
                    n_cur   = (CW'(r_p) < r_n) ? r_p + IW'(1) : r_p;
                    n_steps = '0;
                end else if (r_tail_pend) begin
                    n_s         = w_sum;
                    n_e         = r_bend;
                    n_merge_en  = 1'b1;
                    n_tail_pend = 1'b0;
                    n_j         = '0;
                end
            end
            arac_pkg::S_MRD1: begin
                n_pe = w_rd_end;
            end
            arac_pkg::S_MUPD: begin
                n_cur   = r_cur - IW'(1);
                n_steps = r_steps + SB'(1);
                if (w_remove) begin
                    n_p        = r_cur;
                    n_j        = CW'(r_cur) + CW'(1);
                    n_in_merge = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arac_pkg::S_IDLE;
            r_n         <= '0;
            r_j         <= '0;
            r_rv        <= 1'b0;
            r_wv        <= 1'b0;
            r_have      <= 1'b0;
            r_merge_en  <= 1'b0;
            r_tail_pend <= 1'b0;
            r_ins_pend  <= 1'b0;
            r_in_merge  <= 1'b0;
            r_steps     <= '0;
            r_status    <= arac_pkg::ST_OK;
            r_base      <= '0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_j         <= n_j;
            r_rv        <= n_rv;
            r_wv        <= n_wv;
            r_have      <= n_have;
            r_merge_en  <= n_merge_en;
            r_tail_pend <= n_tail_pend;
            r_ins_pend  <= n_ins_pend;
            r_in_merge  <= n_in_merge;
            r_steps     <= n_steps;
            r_status    <= n_status;
            r_base      <= n_base;
        end
        r_rk       <= n_rk;
        r_wa       <= n_wa;
        r_p        <= n_p;
        r_cur      <= n_cur;
        r_s        <= n_s;
        r_e        <= n_e;
        r_size     <= n_size;
        r_amask    <= n_amask;
        r_bf       <= n_bf;
        r_score    <= n_score;
        r_bidx     <= n_bidx;
        r_bal      <= n_bal;
        r_bstart   <= n_bstart;
        r_bend     <= n_bend;
        r_baligned <= n_baligned;
        r_pe       <= n_pe;
    end

endmodule

`default_nettype wire

// ===== hdl/arac_mem.sv =====
// ============================================================================
// arac_mem
// Range table storage: start and end arrays, one write and one read port.
// ============================================================================
`default_nettype none

module arac_mem #(
    parameter int ENTRIES   = arac_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = arac_pkg::ADDR_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_raddr,
    output logic      [ADDR_BITS-1:0]         o_rd_start,
    output logic      [ADDR_BITS-1:0]         o_rd_end,
    input  wire logic                         i_we_start,
    input  wire logic                         i_we_end,
    input  wire logic [$clog2(ENTRIES)-1:0]   i_waddr,
    input  wire logic [ADDR_BITS-1:0]         i_wstart,
    input  wire logic [ADDR_BITS-1:0]         i_wend
);

    logic [ADDR_BITS-1:0] r_start_mem [ENTRIES];
    logic [ADDR_BITS-1:0] r_end_mem   [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we_start) begin
            r_start_mem[i_waddr] <= i_wstart;
        end
        if (i_we_end) begin
            r_end_mem[i_waddr] <= i_wend;
        end
        o_rd_start <= r_start_mem[i_raddr];
        o_rd_end   <= r_end_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/arac_fit.sv =====
// ============================================================================
// arac_fit
// Three stage fit unit: align the start, take the length, take the slack.
// ============================================================================
`default_nettype none

module arac_fit #(
    parameter int ENTRIES   = arac_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = arac_pkg::ADDR_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_flush,
    input  wire logic                       i_valid,
    input  wire logic [$clog2(ENTRIES)-1:0] i_idx,
    input  wire logic [ADDR_BITS-1:0]       i_start,
    input  wire logic [ADDR_BITS-1:0]       i_end,
    input  wire logic [ADDR_BITS-1:0]       i_amask,
    input  wire logic [ADDR_BITS-1:0]       i_size,
    output arac_pkg::t_fit_flags            o_flags,
    output logic                            o_busy,
    output logic      [$clog2(ENTRIES)-1:0] o_idx,
    output logic      [ADDR_BITS-1:0]       o_al,
    output logic      [ADDR_BITS-1:0]       o_start,
    output logic      [ADDR_BITS-1:0]       o_end,
    output logic      [ADDR_BITS-1:0]       o_slack
);

    localparam int IW = $clog2(ENTRIES);

    logic [2:0]           r_v;
    logic [IW-1:0]        r_idx1, r_idx2;
    logic [ADDR_BITS-1:0] r_al1, r_al2, r_st1, r_st2, r_en1, r_en2, r_len2;
    logic                 r_over1, r_alg1, r_alg2, r_alg3, r_fits3;

    logic [ADDR_BITS:0]   w_sum, w_diff, w_d2;
    logic [ADDR_BITS-1:0] w_len;

    assign w_sum  = {1'b0, i_start} + {1'b0, i_amask};
    assign w_diff = {1'b0, r_en1} - {1'b0, r_al1};
    assign w_len  = (!r_over1 && !w_diff[ADDR_BITS]) ? w_diff[ADDR_BITS-1:0] : '0;
    assign w_d2   = {1'b0, r_len2} - {1'b0, i_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_valid};
        end
        r_idx1  <= i_idx;
        r_st1   <= i_start;
        r_en1   <= i_end;
        r_over1 <= w_sum[ADDR_BITS];
        r_al1   <= w_sum[ADDR_BITS-1:0] & ~i_amask;
        r_alg1  <= ((i_start & i_amask) == '0);

        r_idx2  <= r_idx1;
        r_st2   <= r_st1;
        r_en2   <= r_en1;
        r_al2   <= r_al1;
        r_alg2  <= r_alg1;
        r_len2  <= w_len;

        o_idx   <= r_idx2;
        o_start <= r_st2;
        o_end   <= r_en2;
        o_al    <= r_al2;
        r_alg3  <= r_alg2;
        r_fits3 <= !w_d2[ADDR_BITS];
        o_slack <= w_d2[ADDR_BITS-1:0];
    end

    always_comb begin
        o_flags.valid   = r_v[2];
        o_flags.fits    = r_fits3;
        o_flags.aligned = r_alg3;
        o_busy          = |r_v;
    end

endmodule

`default_nettype wire

// ===== hdl/arac_chk.sv =====
// ============================================================================
// arac_chk
// Port level checks of the address range allocator, bound to the top level.
// ============================================================================
`default_nettype none

module arac_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic [arac_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input wire logic [arac_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [arac_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only the three defined status codes appear.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // A failed request never reports a base address.
    a_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != arac_pkg::ST_OK |-> m_axis_tdata[49:2] == '0)
        else $error("base address on a failed request");

    // One item at a time: no new item is taken while a result is pending,
    // and taking an item closes the input side on the next cycle.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input open while a result is pending");

endmodule

bind address_range_allocator_top arac_chk u_arac_chk (.*);

`default_nettype wire

// ===== test/tb_address_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// Address range allocator testbench
// Drives allocate and free items into the range table and compares every
// result item with a predictor that keeps its own copy of the free table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_address_range_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [47:0] AMASK = 48'hFFFF_FFFF_FFFF;

    // One expected result of the allocator.
    typedef struct {
        logic [1:0]  status;
        logic [47:0] base;
    } t_alloc_result;

    // Holds the predicted free range table and the results still awaited.
    class range_scoreboard;
        logic [63:0] rs [DEPTH];
        logic [63:0] re [DEPTH];
        int count;
        t_alloc_result pending[$];
        int errors;

        function void remove_at(int p);
            if (p < 0 || p >= count) return;
            for (int k = p; k < count - 1; k++) begin
                rs[k] = rs[k + 1];
                re[k] = re[k + 1];
            end
            count--;
        endfunction

        function int insert_sorted(logic [63:0] s, logic [63:0] e);
            int p;
            p = 0;
            while (p < count && re[p] <= e) p++;
            for (int k = count; k > p; k--) begin
                rs[k] = rs[k - 1];
                re[k] = re[k - 1];
            end
            rs[p] = s;
            re[p] = e;
            count++;
            return p;
        endfunction

        function void add_range(logic [63:0] s, logic [63:0] e);
            int p;
            int cur;
            int prv;
            p = insert_sorted(s, e);
            cur = (p + 1 < count) ? p + 1 : p;
            for (int i = 0; i < arac_pkg::MERGE_STEPS; i++) begin
                if (cur <= 0) break;
                prv = cur - 1;
                if (re[prv] == rs[cur]) re[prv] = re[cur];
                if (re[prv] == re[cur]) remove_at(cur);
                cur = prv;
            end
        endfunction

        // Works out the result of one accepted item and updates the table.
        function void note_item(logic op, logic [47:0] s, logic [47:0] e,
                                logic [47:0] size_in, logic [5:0] al_log2, logic bf);
            t_alloc_result r;
            logic [63:0] size;
            logic [63:0] am;
            logic [63:0] score;
            logic [63:0] best_al;
            logic [63:0] b;
            logic [63:0] sum;
            logic [63:0] al;
            logic [63:0] len;
            logic [63:0] os;
            logic [63:0] oe;
            int best;
            bit tail;
            r.status = arac_pkg::ST_OK;
            r.base = '0;
            if (op == arac_pkg::OP_FREE) begin
                if (s >= e) begin
                    // Empty or inverted range: nothing stored.
                end else if (count >= DEPTH) begin
                    r.status = arac_pkg::ST_FULL;
                end else begin
                    add_range({16'd0, s}, {16'd0, e});
                end
            end else begin
                size = {16'd0, size_in};
                am = (64'd1 << al_log2) - 64'd1;
                score = '1;
                best_al = '0;
                best = -1;
                for (int i = 0; i < count; i++) begin
                    b = rs[i];
                    sum = b + am;
                    al = sum & ~am;
                    // A start aligned past the end of the range gives no length.
                    if (sum >= b && re[i] >= al) len = re[i] - al;
                    else len = 0;
                    if (len < size || len - size > score) continue;
                    best = i;
                    best_al = al;
                    score = len - size;
                    if (score == 0 || !bf) break;
                end
                if (best < 0) begin
                    r.status = arac_pkg::ST_NOFIT;
                end else if (best_al == rs[best]) begin
                    rs[best] = rs[best] + size;
                    if (rs[best] == re[best]) remove_at(best);
                    r.base = best_al[47:0];
                end else begin
                    os = rs[best];
                    oe = re[best];
                    tail = (best_al + size) != oe;
                    if (tail && count >= DEPTH) begin
                        r.status = arac_pkg::ST_FULL;
                    end else begin
                        remove_at(best);
                        void'(insert_sorted(os, best_al));
                        if (tail) add_range(best_al + size, oe);
                        r.base = best_al[47:0];
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [47:0] base);
            t_alloc_result x;
            if (pending.size() == 0) begin
                $error("unexpected result item status=%0d block_base=%h", st, base);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (st !== x.status) begin
                $error("status: expected %0d, actual %0d", x.status, st);
                errors++;
            end
            if (base !== x.base) begin
                $error("block_base: expected %h, actual %h", x.base, base);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [arac_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic [arac_pkg::S_TUSER_W-1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [arac_pkg::M_TDATA_W-1:0] m_axis_tdata;

    range_scoreboard board;
    bit stim_done;
    int stall_mode;

    address_range_allocator_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Returns a 48 bit value drawn over all magnitudes, including the extremes.
    function automatic logic [47:0] rand_addr();
        logic [47:0] v;
        int w;
        v = 48'({$urandom, $urandom});
        w = $urandom_range(48, 1);
        case ($urandom_range(9, 0))
            0: return '0;
            1: return AMASK;
            default: return v & (AMASK >> (48 - w));
        endcase
    endfunction

    // Sends one item and records its prediction when the handshake completes.
    task automatic send_item(logic op, logic [47:0] s, logic [47:0] e,
                             logic [47:0] size, logic [5:0] al, logic bf);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {1'b0, bf, al, size, e, s};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(op, s, e, size, al, bf);
    endtask

    // Random gap between bursts of items, with bursts of back to back items.
    task automatic burst_gap(inout int left);
        if (left > 0) begin
            left--;
        end else begin
            left = $urandom_range(12, 0);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    // Receiver: stalls follow a randomly chosen mode: none, rare or frequent.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata[1:0], m_axis_tdata[49:2]);
            case (stall_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(3, 0) != 0);
                default: m_axis_tready <= ($urandom_range(3, 0) == 0);
            endcase
        end
    end

    initial begin
        forever begin
            repeat (300) @(posedge i_clk);
            stall_mode = $urandom_range(2, 0);
        end
    end

    initial begin
        logic [47:0] s;
        logic [47:0] e;
        logic [47:0] sz;
        int left;
        int kind;
        board = new();
        board.count = 0;
        board.errors = 0;
        stim_done = 0;
        stall_mode = 0;
        left = 0;
        i_rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty table, inverted and empty frees, merges,
        // zero size, alignment overflow, exact fits and tail splits.
        send_item(arac_pkg::OP_ALLOC, 0, 0, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 48'h100, 48'h100, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 48'h200, 48'h100, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 48'h1000, 48'h2000, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 48'h3000, 48'h4000, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 48'h2000, 48'h3000, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, 0, 48'h10, 0, 0, 0);
        send_item(arac_pkg::OP_FREE, AMASK - 48'hFF, AMASK, 0, 0, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 0, 0, 1);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h8, 0, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h10, 6'd47, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h100, 6'd12, 1);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h30, 6'd9, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h8, 6'd0, 1);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h80, 6'd4, 1);
        send_item(arac_pkg::OP_ALLOC, 0, 0, AMASK, 6'd0, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h2800, 6'd3, 1);
        send_item(arac_pkg::OP_FREE, 48'h500000, 48'h500100, 0, 0, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h100, 6'd0, 1);
        // Fill the table with disjoint ranges to reach the full cases.
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(arac_pkg::OP_FREE, 48'h10_0000 * (i + 1),
                      48'h10_0000 * (i + 1) + 48'h803, 0, 0, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h10, 6'd4, 0);
        send_item(arac_pkg::OP_ALLOC, 0, 0, 48'h800, 6'd0, 1);

        // Random part: mostly allocations and frees of nearby ranges so the
        // table keeps churning, with a share of wide random noise.
        for (int n = 0; n < 2000; n++) begin
            burst_gap(left);
            kind = $urandom_range(9, 0);
            s = {16'd0, $urandom} & 48'h00FF_FFF0;
            sz = 48'($urandom_range(4096, 1));
            if (kind < 4) begin
                send_item(arac_pkg::OP_FREE, s, s + sz, rand_addr(), 6'($urandom),
                          1'($urandom));
            end else if (kind < 8) begin
                send_item(arac_pkg::OP_ALLOC, rand_addr(), rand_addr(),
                          ($urandom_range(3, 0) == 0) ? 48'd0 : sz >> $urandom_range(6, 0),
                          6'($urandom_range(10, 0)), 1'($urandom));
            end else begin
                s = rand_addr();
                e = rand_addr();
                sz = rand_addr();
                send_item(1'($urandom), s, e, sz, 6'($urandom_range(63, 0)),
                          1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        stim_done = 1;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Timeout: far beyond the slowest correct run of this many items.
    initial begin
        #200ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
